[hw/rtl/lbbe_pkg.sv]
// ----------------------------------------------------------------------------
// lbbe_pkg
// Shared constants, codes and controller/datapath interface types for the
// LRU byte-budget evictor.
// ----------------------------------------------------------------------------
package lbbe_pkg;

    localparam int ENTRIES   = 64;
    localparam int SLOT_W    = $clog2(ENTRIES);
    localparam int SIZE_BITS = 32;
    localparam int TOTAL_W   = 38;
    localparam int COUNT_W   = $clog2(ENTRIES + 1);
    localparam int CFG_IDX_W = 1;

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_TOUCH    = 1'b1;

    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_EVICT = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SOFT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HARD = 1'b1;

    typedef struct packed {
        logic       load;
        logic       rd_oldest;
        logic       cut;
        logic       push_a;
        logic       push_b;
        logic       reg_new;
        logic       evict;
        logic       ack;
        logic [1:0] ack_status;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic live;
        logic over_hard;
        logic ev_go;
        logic out_free;
    } stat_t;

endpackage

[hw/rtl/lbbe_ram.sv]
// ----------------------------------------------------------------------------
// lbbe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/lbbe_ctrl.sv]
// ----------------------------------------------------------------------------
// lbbe_ctrl
// Sequencer: steps each item through list cut, push, eviction walk and
// acknowledgement.
// ----------------------------------------------------------------------------
module lbbe_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  lbbe_pkg::stat_t stat,
    output lbbe_pkg::cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECIDE = 9'b000000010,
        S_CUT    = 9'b000000100,
        S_PUSH_A = 9'b000001000,
        S_PUSH_B = 9'b000010000,
        S_CHK_HD = 9'b000100000,
        S_EV_CHK = 9'b001000000,
        S_EV_WR  = 9'b010000000,
        S_ACK    = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] ack_st_reg, ack_st_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            ack_st_reg <= lbbe_pkg::ST_OK;
        end else begin
            state_reg  <= state_next;
            ack_st_reg <= ack_st_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        ack_st_next    = ack_st_reg;
        cmd            = '0;
        cmd.ack_status = ack_st_reg;
        s_tready       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                // hold off the input while reset is applied
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load    = 1'b1;
                    ack_st_next = lbbe_pkg::ST_OK;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (stat.op == lbbe_pkg::OP_TOUCH) begin
                    if (stat.live) begin
                        state_next = S_CUT;
                    end else begin
                        ack_st_next = lbbe_pkg::ST_IGNORED;
                        state_next  = S_ACK;
                    end
                end else if (stat.live) begin
                    ack_st_next = lbbe_pkg::ST_REFUSED;
                    state_next  = S_ACK;
                end else begin
                    cmd.reg_new = 1'b1;
                    state_next  = S_PUSH_A;
                end
            end
            S_CUT: begin
                cmd.cut    = 1'b1;
                state_next = S_PUSH_A;
            end
            S_PUSH_A: begin
                cmd.push_a = 1'b1;
                state_next = S_PUSH_B;
            end
            S_PUSH_B: begin
                cmd.push_b = 1'b1;
                state_next = (stat.op == lbbe_pkg::OP_TOUCH) ? S_ACK : S_CHK_HD;
            end
            S_CHK_HD: begin
                state_next = stat.over_hard ? S_EV_CHK : S_ACK;
            end
            S_EV_CHK: begin
                cmd.rd_oldest = 1'b1;
                state_next    = stat.ev_go ? S_EV_WR : S_ACK;
            end
            S_EV_WR: begin
                cmd.rd_oldest = 1'b1;
                if (stat.out_free) begin
                    cmd.cut    = 1'b1;
                    cmd.evict  = 1'b1;
                    state_next = S_EV_CHK;
                end
            end
            S_ACK: begin
                if (stat.out_free) begin
                    cmd.ack    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/lbbe_dp.sv]
// ----------------------------------------------------------------------------
// lbbe_dp
// Datapath: link and size memories, live bits, list ends, byte total,
// limit registers and the result register.
// ----------------------------------------------------------------------------
module lbbe_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lbbe_pkg::cmd_t                     cmd,
    output lbbe_pkg::stat_t                    stat,
    input  logic                               in_op,
    input  logic [lbbe_pkg::SLOT_W-1:0]        in_slot,
    input  logic [lbbe_pkg::SIZE_BITS-1:0]     in_size,
    input  logic                               cfg_wr_en,
    input  logic [lbbe_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [lbbe_pkg::TOTAL_W-1:0]       cfg_wdata,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               out_kind,
    output logic [lbbe_pkg::SLOT_W-1:0]        out_slot,
    output logic [lbbe_pkg::TOTAL_W-1:0]       out_total,
    output logic [1:0]                         out_status,
    output logic                               out_last
);

    localparam int SW = lbbe_pkg::SLOT_W;
    localparam int TW = lbbe_pkg::TOTAL_W;
    localparam int CW = lbbe_pkg::COUNT_W;
    localparam int ZW = lbbe_pkg::SIZE_BITS;

    logic                   op_reg;
    logic [SW-1:0]          slot_reg;
    logic [ZW-1:0]          size_reg;
    logic [lbbe_pkg::ENTRIES-1:0] live_reg;
    logic [SW-1:0]          newest_reg, newest_next;
    logic [SW-1:0]          oldest_reg, oldest_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [TW-1:0]          soft_reg, hard_reg, soft_eff_reg;

    logic                   oval_reg;
    logic                   okind_reg;
    logic [SW-1:0]          oslot_reg;
    logic [TW-1:0]          ototal_reg;
    logic [1:0]             ostat_reg;
    logic                   olast_reg;

    logic [SW-1:0]          raddr, cut_slot;
    logic [SW-1:0]          older_rd, newer_rd;
    logic [ZW-1:0]          bytes_rd;
    logic                   older_we, newer_we;
    logic [SW-1:0]          older_wa, older_wd, newer_wa, newer_wd;
    logic [CW-1:0]          count_dec;

    assign cut_slot = cmd.rd_oldest ? oldest_reg : slot_reg;
    assign raddr    = cut_slot;

    lbbe_ram #(.WIDTH(SW), .DEPTH(lbbe_pkg::ENTRIES)) u_older (
        .aclk(aclk), .we(older_we), .waddr(older_wa), .wdata(older_wd),
        .raddr(raddr), .rdata(older_rd)
    );

    lbbe_ram #(.WIDTH(SW), .DEPTH(lbbe_pkg::ENTRIES)) u_newer (
        .aclk(aclk), .we(newer_we), .waddr(newer_wa), .wdata(newer_wd),
        .raddr(raddr), .rdata(newer_rd)
    );

    lbbe_ram #(.WIDTH(ZW), .DEPTH(lbbe_pkg::ENTRIES)) u_bytes (
        .aclk(aclk), .we(cmd.reg_new), .waddr(slot_reg), .wdata(size_reg),
        .raddr(raddr), .rdata(bytes_rd)
    );

    assign count_dec = (count_reg != '0) ? count_reg - CW'(1) : count_reg;

    // link writes, list-end, count and byte-total updates for cut, push, register and evict
    always_comb begin
        older_we    = 1'b0;
        older_wa    = cut_slot;
        older_wd    = cut_slot;
        newer_we    = 1'b0;
        newer_wa    = cut_slot;
        newer_wd    = cut_slot;
        newest_next = newest_reg;
        oldest_next = oldest_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        if (cmd.cut) begin
            if (cut_slot != newest_reg) begin
                older_we = 1'b1;
                older_wa = newer_rd;
                older_wd = older_rd;
            end else begin
                newest_next = older_rd;
            end
            if (cut_slot != oldest_reg) begin
                newer_we = 1'b1;
                newer_wa = older_rd;
                newer_wd = newer_rd;
            end else begin
                oldest_next = newer_rd;
            end
            count_next = count_dec;
            if (count_dec == '0) begin
                newest_next = '0;
                oldest_next = '0;
            end
        end
        if (cmd.push_a) begin
            older_we = 1'b1;
            older_wa = slot_reg;
            older_wd = (count_reg == '0) ? slot_reg : newest_reg;
            newer_we = 1'b1;
            newer_wa = slot_reg;
            newer_wd = slot_reg;
        end
        if (cmd.push_b) begin
            if (count_reg == '0) begin
                oldest_next = slot_reg;
            end else begin
                newer_we = 1'b1;
                newer_wa = newest_reg;
                newer_wd = slot_reg;
            end
            newest_next = slot_reg;
            count_next  = count_reg + CW'(1);
        end
        if (cmd.reg_new) begin
            total_next = total_reg + TW'(size_reg);
        end
        if (cmd.evict) begin
            total_next = total_reg - TW'(bytes_rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg   <= '0;
            newest_reg <= '0;
            oldest_reg <= '0;
            count_reg  <= '0;
            total_reg  <= '0;
            soft_reg   <= '1;
            hard_reg   <= '1;
            oval_reg   <= 1'b0;
        end else begin
            newest_reg <= newest_next;
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            if (cmd.reg_new) begin
                live_reg[slot_reg] <= 1'b1;
            end
            if (cmd.evict) begin
                live_reg[oldest_reg] <= 1'b0;
            end
            if (cfg_wr_en && cfg_addr == lbbe_pkg::CFG_SOFT) begin
                soft_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_addr == lbbe_pkg::CFG_HARD) begin
                hard_reg <= cfg_wdata;
            end
            if (cmd.ack || cmd.evict) begin
                oval_reg <= 1'b1;
            end else if (out_ready) begin
                oval_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        soft_eff_reg <= (soft_reg < hard_reg) ? soft_reg : hard_reg;
        if (cmd.load) begin
            op_reg   <= in_op;
            slot_reg <= in_slot;
            size_reg <= in_size;
        end
        if (cmd.evict) begin
            okind_reg  <= lbbe_pkg::KIND_EVICT;
            oslot_reg  <= oldest_reg;
            ototal_reg <= total_next;
            ostat_reg  <= lbbe_pkg::ST_OK;
            olast_reg  <= 1'b0;
        end else if (cmd.ack) begin
            okind_reg  <= lbbe_pkg::KIND_ACK;
            oslot_reg  <= slot_reg;
            ototal_reg <= total_reg;
            ostat_reg  <= cmd.ack_status;
            olast_reg  <= 1'b1;
        end
    end

    assign stat.op        = op_reg;
    assign stat.live      = live_reg[slot_reg];
    assign stat.over_hard = total_reg > hard_reg;
    assign stat.ev_go     = (total_reg > soft_eff_reg) && (count_reg > CW'(1))
                            && (oldest_reg != slot_reg);
    assign stat.out_free  = !oval_reg || out_ready;

    assign out_valid  = oval_reg;
    assign out_kind   = okind_reg;
    assign out_slot   = oslot_reg;
    assign out_total  = ototal_reg;
    assign out_status = ostat_reg;
    assign out_last   = olast_reg;

endmodule

[hw/rtl/lru_byte_budget_evictor.sv]
// ----------------------------------------------------------------------------
// lru_byte_budget_evictor
// LRU recency list with a byte budget; evicts oldest slots past the limit.
//
//   channel  dir  ports                     contents
//   s_       in   tvalid/tready/tdata/tuser item: opcode, slot, size_bytes
//   m_       out  tvalid/tready/tdata/tuser result: kind, slot, total, status
//   cfg_     in   wr_en/addr/wdata          soft floor (0), hard ceiling (1)
//
// A refused or ignored item goes straight to the acknowledge; a touch cuts and
// pushes its slot; a register pushes it and, once the total passes the hard
// ceiling, walks evictions; the registered link-memory reads set each step.
// One item is in work at a time; s_tready rises again after the acknowledge.
// Reset is synchronous, active low, and empties the list at once.
// A stalled m_ side holds the sequencer at the next beat it has to issue.
// ----------------------------------------------------------------------------
module lru_byte_budget_evictor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [5:0] slot, [37:6] size_bytes, zero fill
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [5:0] result_slot, [43:6] total_bytes_now
    output logic [2:0]  m_tuser,   // [0] kind, [2:1] status
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [lbbe_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [lbbe_pkg::TOTAL_W-1:0]   cfg_wdata
);

    lbbe_pkg::cmd_t  cmd;
    lbbe_pkg::stat_t stat;
    logic                          o_kind;
    logic [lbbe_pkg::SLOT_W-1:0]   o_slot;
    logic [lbbe_pkg::TOTAL_W-1:0]  o_total;
    logic [1:0]                    o_status;

    lbbe_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid),
        .s_tready(s_tready), .stat(stat), .cmd(cmd)
    );

    lbbe_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_op(s_tuser[0]), .in_slot(s_tdata[5:0]), .in_size(s_tdata[37:6]),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_kind(o_kind),
        .out_slot(o_slot), .out_total(o_total), .out_status(o_status),
        .out_last(m_tlast)
    );

    assign m_tdata = {4'b0000, o_total, o_slot};
    assign m_tuser = {o_status, o_kind};

endmodule

[hw/rtl/lbbe_checker.sv]
// ----------------------------------------------------------------------------
// lbbe_checker
// Port-level checks on the evictor, bound to the top level.
// ----------------------------------------------------------------------------
module lbbe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled beat holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one item in work at a time
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // eviction notices are never final and always ok
    a_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == lbbe_pkg::KIND_EVICT |->
            !m_tlast && m_tuser[2:1] == lbbe_pkg::ST_OK)
        else $error("bad eviction beat");

    // the final beat is the acknowledge
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == lbbe_pkg::KIND_ACK |-> m_tlast)
        else $error("acknowledge without last");

endmodule

bind lru_byte_budget_evictor lbbe_checker u_lbbe_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
);
